// File: hdl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  typedef logic [63:0] word_t;

  typedef enum logic [1:0] {
    OP_LOAD_BASE = 2'd0,
    OP_LOAD_EXP  = 2'd1,
    OP_LOAD_MOD  = 2'd2,
    OP_START     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CAND_T  = 2'd0,
    CAND_D1 = 2'd1,
    CAND_D2 = 2'd2
  } cand_t;

  typedef enum logic [1:0] {
    KIND_REDUCE = 2'd0,
    KIND_MULT   = 2'd1,
    KIND_SQUARE = 2'd2
  } kind_t;

  localparam logic REG_ACTIVE_WORDS = 1'b0;

  typedef struct packed {
    word_t m;
    word_t y;
    word_t c0;
    word_t c1;
    word_t c2;
  } ring_t;

  typedef struct packed {
    logic  init;
    logic  launch;
    logic  rotate;
    logic  shift_a;
    logic  shift_e;
    logic  store;
    logic  out_step;
    kind_t kind;
    cand_t sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic active;
    logic tail;
    logic low;
  } cell_pos_t;

  typedef struct packed {
    logic wr_base;
    logic wr_exp;
    logic wr_mod;
  } cell_wr_t;

endpackage

// File: hdl/mexp_cell.sv
// One word cell of the operand ring: stores, working words and ring stage.
module mexp_cell (
  input  logic               clk,
  input  logic               rst,
  input  mexp_pkg::cell_ctrl_t ctrl,
  input  mexp_pkg::cell_pos_t  pos,
  input  mexp_pkg::cell_wr_t   wr,
  input  mexp_pkg::word_t    wdata,
  input  mexp_pkg::ring_t    ring_nb,
  input  mexp_pkg::ring_t    ring_fb,
  output mexp_pkg::ring_t    ring_q,
  input  mexp_pkg::word_t    res_nb,
  output mexp_pkg::word_t    res_q,
  input  logic               a_lo_in,
  output logic               a_hi_out,
  input  logic               e_hi_in,
  output logic               e_lo_out,
  output logic               e_nz_hi,
  output logic               m_nz
);
  import mexp_pkg::*;

  word_t base_w;
  word_t exp_w;
  word_t mod_w;
  word_t a_w;
  word_t e_w;
  word_t b_w;
  word_t cand;
  word_t one_w;

  assign one_w = pos.low ? word_t'(1) : '0;

  always_comb begin
    unique case (ctrl.sel)
      CAND_T:  cand = ring_q.c0;
      CAND_D1: cand = ring_q.c1;
      CAND_D2: cand = ring_q.c2;
      default: cand = ring_q.c0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_w <= '0;
      exp_w  <= '0;
      mod_w  <= '0;
    end else begin
      if (wr.wr_base) base_w <= wdata;
      if (wr.wr_exp)  exp_w  <= wdata;
      if (wr.wr_mod)  mod_w  <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      ring_q.m <= pos.active ? mod_w : '0;
    end else if (ctrl.launch) begin
      ring_q.y  <= (ctrl.kind == KIND_REDUCE) ? one_w : b_w;
      ring_q.c0 <= '0;
      ring_q.c1 <= '0;
      ring_q.c2 <= '0;
    end else if (ctrl.rotate) begin
      ring_q <= pos.tail ? ring_fb : ring_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.launch) begin
      unique case (ctrl.kind)
        KIND_REDUCE: a_w <= pos.active ? base_w : '0;
        KIND_MULT:   a_w <= res_q;
        KIND_SQUARE: a_w <= b_w;
        default:     a_w <= b_w;
      endcase
    end else if (ctrl.shift_a) begin
      a_w <= {a_w[62:0], a_lo_in};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      e_w <= pos.active ? exp_w : '0;
    end else if (ctrl.shift_e) begin
      e_w <= {e_hi_in, e_w[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      res_q <= one_w;
    end else if (ctrl.store && ctrl.kind == KIND_MULT) begin
      res_q <= cand;
    end else if (ctrl.out_step) begin
      res_q <= res_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.store && ctrl.kind != KIND_MULT) begin
      b_w <= cand;
    end
  end

  assign a_hi_out = a_w[63];
  assign e_lo_out = e_w[0];
  assign e_nz_hi  = |e_w[63:1];
  assign m_nz     = |ring_q.m;

endmodule

// File: hdl/mexp_alu.sv
// Word-serial step unit: 2R + bit*Y, minus M and 2M, with carries across words.
module mexp_alu (
  input  logic            clk,
  input  logic            rst,
  input  mexp_pkg::ring_t head,
  input  logic            abit,
  input  logic            clear,
  input  logic            step,
  input  logic            last,
  output mexp_pkg::ring_t fb,
  output mexp_pkg::cand_t sel
);
  import mexp_pkg::*;

  logic        rc;
  logic        cy;
  logic        b1;
  logic        b2;
  logic        mc;
  word_t       r;
  word_t       t;
  word_t       addv;
  word_t       m2;
  logic [64:0] s_sum;
  logic [64:0] d1_sum;
  logic [64:0] d2_sum;
  logic [1:0]  ovf;
  logic        d1_ok;
  logic        d2_ok;
  cand_t       sel_new;

  always_comb begin
    unique case (sel)
      CAND_T:  r = head.c0;
      CAND_D1: r = head.c1;
      CAND_D2: r = head.c2;
      default: r = head.c0;
    endcase
  end

  always_comb begin
    t      = {r[62:0], rc};
    addv   = abit ? head.y : '0;
    m2     = {head.m[62:0], mc};
    s_sum  = {1'b0, t} + {1'b0, addv} + 65'(cy);
    d1_sum = {1'b0, s_sum[63:0]} - {1'b0, head.m} - 65'(b1);
    d2_sum = {1'b0, s_sum[63:0]} - {1'b0, m2} - 65'(b2);
    ovf    = 2'(r[63]) + 2'(s_sum[64]);
    d1_ok  = ovf >= 2'(d1_sum[64]);
    d2_ok  = ovf >= (2'(head.m[63]) + 2'(d2_sum[64]));
    if (d2_ok) begin
      sel_new = CAND_D2;
    end else if (d1_ok) begin
      sel_new = CAND_D1;
    end else begin
      sel_new = CAND_T;
    end
  end

  assign fb.m  = head.m;
  assign fb.y  = head.y;
  assign fb.c0 = s_sum[63:0];
  assign fb.c1 = d1_sum[63:0];
  assign fb.c2 = d2_sum[63:0];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      rc  <= 1'b0;
      cy  <= 1'b0;
      b1  <= 1'b0;
      b2  <= 1'b0;
      mc  <= 1'b0;
      sel <= CAND_T;
    end else if (step) begin
      if (last) begin
        rc  <= 1'b0;
        cy  <= 1'b0;
        b1  <= 1'b0;
        b2  <= 1'b0;
        mc  <= 1'b0;
        sel <= sel_new;
      end else begin
        rc  <= r[63];
        cy  <= s_sum[64];
        b1  <= d1_sum[64];
        b2  <= d2_sum[64];
        mc  <= head.m[63];
      end
    end
  end

endmodule

// File: hdl/modular_exponentiation.sv
// Top level: modular exponentiation over a ring of word cells.
//
// Computes base^exponent mod modulus over n = active_words 64-bit words
// (0 counts as 1, above OPERAND_WORDS as OPERAND_WORDS). Loads are taken
// while busy is low. A start runs right-to-left square-and-multiply;
// each modular multiplication is 64*n bit steps, and each bit step rotates
// the n-word ring once past the single word unit at its head, so one
// multiplication is those bit steps plus a store and a decision state.
// A run holds busy until the last result word has gone out; its length
// grows with the index of the top set exponent bit and the number of set
// bits, and the products are skipped when the modulus or the exponent is
// zero. Results then come one word per cycle marked by result_valid,
// word 0 first; the receiver cannot stall them and must take each beat.
module modular_exponentiation #(
  parameter int OPERAND_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [4:0]  word_index,
  input  logic [63:0] word_data,
  output logic        result_valid,
  output logic [63:0] result_word,
  output logic [4:0]  result_index,
  output logic        last_word,
  output logic        modulus_zero,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mexp_pkg::*;

  localparam int N  = OPERAND_WORDS;
  localparam int NW = $clog2(N + 1);
  localparam int BW = NW + 6;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_PASS  = 7'b0001000,
    S_STORE = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t      state;
  state_t      state_next;
  kind_t       kind_q;
  kind_t       kind_next;
  logic [5:0]  active_words;
  logic [6:0]  n7;
  logic [NW-1:0] n;
  logic [NW-1:0] nm1;
  logic [NW-1:0] wcnt;
  logic [NW-1:0] ocnt;
  logic [BW-1:0] bitcnt;
  logic [BW-1:0] bit_last;
  logic        zmod;
  logic        ld_go;
  logic        alu_last;
  cell_ctrl_t  ctrl;
  cand_t       sel;
  ring_t       ring_fb;

  ring_t       ring_q   [N];
  word_t       res_q    [N];
  logic [N-1:0] a_hi_vec;
  logic [N-1:0] e_lo_vec;
  logic [N-1:0] e_nz_vec;
  logic [N-1:0] m_nz_vec;
  logic [N-1:0] tail_vec;
  logic [N-1:0] low_mask;
  logic        abit;
  logic        m_any;
  logic        e_any;
  logic        e_hi_any;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_WORDS) ? {26'b0, active_words} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_words <= 6'd32;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_WORDS) begin
      active_words <= pwdata[5:0];
    end
  end

  always_comb begin
    if (active_words == 6'd0) begin
      n7 = 7'd1;
    end else if ({1'b0, active_words} > 7'(N)) begin
      n7 = 7'(N);
    end else begin
      n7 = {1'b0, active_words};
    end
    n        = NW'(n7);
    nm1      = n - NW'(1);
    bit_last = {nm1, 6'h3F};
  end

  assign busy  = (state != S_IDLE);
  assign ld_go = start && !busy && operation != OP_START;

  // cell row
  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      cell_pos_t pos;
      cell_wr_t  wr;
      ring_t     nb;
      word_t     rnb;
      logic      a_lo;
      logic      e_hi;
      logic      hit;

      assign hit        = ld_go && (7'(word_index) == 7'(k));
      assign wr.wr_base = hit && operation == OP_LOAD_BASE;
      assign wr.wr_exp  = hit && operation == OP_LOAD_EXP;
      assign wr.wr_mod  = hit && operation == OP_LOAD_MOD;
      assign pos.active = NW'(k) < n;
      assign pos.tail   = NW'(k) == nm1;
      assign pos.low    = (k == 0);
      assign tail_vec[k] = pos.tail;

      if (k == N - 1) begin : g_top
        assign nb   = '0;
        assign rnb  = '0;
        assign e_hi = 1'b0;
      end else begin : g_mid
        assign nb   = ring_q[k+1];
        assign rnb  = res_q[k+1];
        assign e_hi = e_lo_vec[k+1];
      end

      if (k == 0) begin : g_bot
        assign a_lo = 1'b0;
      end else begin : g_up
        assign a_lo = a_hi_vec[k-1];
      end

      mexp_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .pos      (pos),
        .wr       (wr),
        .wdata    (word_data),
        .ring_nb  (nb),
        .ring_fb  (ring_fb),
        .ring_q   (ring_q[k]),
        .res_nb   (rnb),
        .res_q    (res_q[k]),
        .a_lo_in  (a_lo),
        .a_hi_out (a_hi_vec[k]),
        .e_hi_in  (e_hi),
        .e_lo_out (e_lo_vec[k]),
        .e_nz_hi  (e_nz_vec[k]),
        .m_nz     (m_nz_vec[k])
      );
    end
  endgenerate

  assign low_mask = N'(1);
  assign abit     = |(a_hi_vec & tail_vec);
  assign m_any    = |m_nz_vec;
  assign e_any    = |e_nz_vec || |e_lo_vec;
  assign e_hi_any = |e_nz_vec || |(e_lo_vec & ~low_mask);
  assign alu_last = (state == S_PASS) && (wcnt == nm1);

  mexp_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .head  (ring_q[0]),
    .abit  (abit),
    .clear (ctrl.launch),
    .step  (ctrl.rotate),
    .last  (alu_last),
    .fb    (ring_fb),
    .sel   (sel)
  );

  // sequencer
  always_comb begin
    ctrl       = '0;
    ctrl.sel   = sel;
    ctrl.kind  = kind_q;
    state_next = state;
    kind_next  = kind_q;
    unique case (state)
      S_IDLE: begin
        if (start && operation == OP_START) state_next = S_INIT;
      end
      S_INIT: begin
        ctrl.init  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!m_any || !e_any) begin
          state_next = S_OUT;
        end else begin
          ctrl.launch = 1'b1;
          ctrl.kind   = KIND_REDUCE;
          kind_next   = KIND_REDUCE;
          state_next  = S_PASS;
        end
      end
      S_PASS: begin
        ctrl.rotate = 1'b1;
        if (wcnt == nm1) begin
          ctrl.shift_a = 1'b1;
          if (bitcnt == bit_last) state_next = S_STORE;
        end
      end
      S_STORE: begin
        ctrl.store = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (kind_q != KIND_MULT && e_lo_vec[0]) begin
          ctrl.launch = 1'b1;
          ctrl.kind   = KIND_MULT;
          kind_next   = KIND_MULT;
          state_next  = S_PASS;
        end else if (e_hi_any) begin
          ctrl.launch  = 1'b1;
          ctrl.shift_e = 1'b1;
          ctrl.kind    = KIND_SQUARE;
          kind_next    = KIND_SQUARE;
          state_next   = S_PASS;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        ctrl.out_step = 1'b1;
        if (ocnt == nm1) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_q <= KIND_REDUCE;
      wcnt   <= '0;
      bitcnt <= '0;
      ocnt   <= '0;
      zmod   <= 1'b0;
    end else begin
      state  <= state_next;
      kind_q <= kind_next;
      if (ctrl.launch) begin
        wcnt   <= '0;
        bitcnt <= '0;
      end else if (ctrl.rotate) begin
        if (wcnt == nm1) begin
          wcnt   <= '0;
          bitcnt <= bitcnt + BW'(1);
        end else begin
          wcnt <= wcnt + NW'(1);
        end
      end
      if (state == S_CHECK) zmod <= !m_any;
      if (ctrl.out_step) ocnt <= (ocnt == nm1) ? '0 : ocnt + NW'(1);
    end
  end

  assign result_valid = (state == S_OUT);
  assign result_word  = zmod ? '0 : res_q[0];
  assign result_index = 5'(ocnt);
  assign last_word    = (ocnt == nm1);
  assign modulus_zero = zmod;

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_word |=> !result_valid)
    else $error("result beat after last word");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_word |=>
      result_valid && result_index == 5'($past(result_index) + 5'd1))
    else $error("result beats not consecutive");

  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE |-> wcnt == '0)
    else $error("ring not at home position on store");

endmodule

// File: verif/modular_exponentiation_tb.sv
// Testbench for the modular exponentiation block: directed table plus random beats.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [4:0]  index;
    logic        last;
    logic        zero_mod;
  } power_word_t;

  typedef struct {
    bit          cfg;
    op_t         op;
    bit [4:0]    index;
    bit [63:0]   data;
    bit          typed;
    bit [63:0]   word0;
    bit          zero_mod;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [4:0]  word_index;
  logic [63:0] word_data;
  logic        result_valid;
  logic [63:0] result_word;
  logic [4:0]  result_index;
  logic        last_word;
  logic        modulus_zero;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit [63:0]   base_words[32];
  bit [63:0]   exp_words[32];
  bit [63:0]   mod_words[32];
  bit [5:0]    word_count_reg;
  power_word_t power_words[$];
  plan_row_t   plan[$];
  int          errors;

  modular_exponentiation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .word_index(word_index), .word_data(word_data),
    .result_valid(result_valid), .result_word(result_word),
    .result_index(result_index), .last_word(last_word),
    .modulus_zero(modulus_zero),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #150_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    errors++;
  endtask

  function automatic int used_words();
    int n;
    n = int'(word_count_reg);
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  function automatic bit [2047:0] mod_power(int n, output bit zero_mod);
    bit [2047:0] b, e, m, r;
    bit [4095:0] t;
    b = '0;
    e = '0;
    m = '0;
    for (int i = 0; i < n; i++) begin
      b[64*i +: 64] = base_words[i];
      e[64*i +: 64] = exp_words[i];
      m[64*i +: 64] = mod_words[i];
    end
    zero_mod = (m == '0);
    if (zero_mod) return '0;
    if (e == '0) return 2048'd1;
    b = b % m;
    r = 2048'd1;
    while (e != '0) begin
      if (e[0]) begin
        t = {2048'b0, r} * {2048'b0, b};
        t = t % {2048'b0, m};
        r = t[2047:0];
      end
      e = e >> 1;
      if (e != '0) begin
        t = {2048'b0, b} * {2048'b0, b};
        t = t % {2048'b0, m};
        b = t[2047:0];
      end
    end
    return r;
  endfunction

  task automatic apply_beat(plan_row_t row);
    int n;
    bit zf;
    bit [2047:0] r;
    power_word_t w;
    n = used_words();
    case (row.op)
      OP_LOAD_BASE: base_words[row.index] = row.data;
      OP_LOAD_EXP:  exp_words[row.index] = row.data;
      OP_LOAD_MOD:  mod_words[row.index] = row.data;
      default: begin
        if (row.typed) begin
          r = '0;
          r[63:0] = row.word0;
          zf = row.zero_mod;
        end else begin
          r = mod_power(n, zf);
        end
        for (int k = 0; k < n; k++) begin
          w.word = r[64*k +: 64];
          w.index = k[4:0];
          w.last = (k == n - 1);
          w.zero_mod = zf;
          power_words.push_back(w);
        end
      end
    endcase
  endtask

  task automatic send_beat(plan_row_t row);
    int gap;
    start <= 1'b1;
    operation <= row.op;
    word_index <= row.index;
    word_data <= row.data;
    do @(negedge clk); while (busy);
    @(posedge clk);
    apply_beat(row);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (busy || power_words.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_word_count(bit [5:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {26'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    word_count_reg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    power_word_t w;
    if (!rst && result_valid) begin
      if (power_words.size() == 0) begin
        report("unexpected beat", '0, result_word);
      end else begin
        w = power_words.pop_front();
        if (result_word !== w.word) report("result_word", w.word, result_word);
        if (result_index !== w.index)
          report("result_index", 64'(w.index), 64'(result_index));
        if (last_word !== w.last) report("last_word", 64'(w.last), 64'(last_word));
        if (modulus_zero !== w.zero_mod)
          report("modulus_zero", 64'(w.zero_mod), 64'(modulus_zero));
      end
    end
  end

  initial begin
    plan_row_t row;
    int n, pick;
    bit [5:0] phases[3];
    rst = 1'b1;
    start = 1'b0;
    operation = '0;
    word_index = '0;
    word_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    word_count_reg = 6'd32;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back('{0, OP_START, 0, 0, 1, 64'd0, 1});
    plan.push_back('{0, OP_LOAD_MOD, 0, 64'd7, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_BASE, 0, 64'd3, 0, 0, 0});
    plan.push_back('{0, OP_START, 5'd9, '1, 1, 64'd1, 0});
    plan.push_back('{0, OP_LOAD_EXP, 0, 64'd1, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 1, 64'd3, 0});
    plan.push_back('{0, OP_LOAD_MOD, 5'd31, '1, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_BASE, 5'd31, '1, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_EXP, 0, 64'd0, 0, 0, 0});
    plan.push_back('{1, OP_START, 0, 64'd63, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 1, 64'd1, 0});
    plan.push_back('{1, OP_START, 0, 64'd0, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_MOD, 0, 64'd1, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 1, 64'd1, 0});
    plan.push_back('{0, OP_LOAD_EXP, 0, 64'd5, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 1, 64'd0, 0});
    plan.push_back('{0, OP_LOAD_MOD, 0, 64'd0, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 1, 64'd0, 1});
    plan.push_back('{0, OP_LOAD_MOD, 0, '1, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_BASE, 0, '1, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_EXP, 0, '1, 0, 0, 0});
    plan.push_back('{0, OP_LOAD_EXP, 5'd31, '1, 0, 0, 0});
    plan.push_back('{0, OP_START, 0, 0, 0, 0, 0});

    foreach (plan[i]) begin
      if (plan[i].cfg) write_word_count(plan[i].data[5:0]);
      else send_beat(plan[i]);
    end

    phases = '{6'd1, 6'd2, 6'd1};
    foreach (phases[p]) begin
      write_word_count(phases[p]);
      n = used_words();
      for (int i = 0; i < n; i++) begin
        send_beat('{0, OP_LOAD_BASE, i[4:0], rand64(), 0, 0, 0});
        send_beat('{0, OP_LOAD_MOD, i[4:0], rand64(), 0, 0, 0});
        send_beat('{0, OP_LOAD_EXP, i[4:0], rand64() >> $urandom_range(48, 63), 0, 0, 0});
      end
      repeat (22) begin
        pick = $urandom_range(0, 9);
        row = '{0, OP_START, 0, rand64(), 0, 0, 0};
        row.index = 5'($urandom_range(0, 31));
        if (pick < 7) begin
          row.op = op_t'($urandom_range(0, 2));
          if (pick < 6) row.index = 5'($urandom_range(0, n - 1));
          if (row.op == OP_LOAD_MOD && $urandom_range(0, 7) == 0) row.data = '0;
          if (row.op == OP_LOAD_EXP && row.index < 3 && !(n == 1 && row.index == 0))
            row.data = row.data >> $urandom_range(48, 63);
        end
        send_beat(row);
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mexp_pkg.sv
hdl/mexp_cell.sv
hdl/mexp_alu.sv
hdl/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
